/* design/sus_pkg.sv */
// Shared types and constants for the sorted unique set block.
// No dependencies; every other design file imports this package.
package sus_pkg;

   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 3;
   localparam int POS_W    = 8;
   localparam int ERROR_W  = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TEST   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_INDEX  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [ERROR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_FULL  = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic capture;   // register compare flags for a new transfer
      logic ins;       // open a slot at the insert point and shift right
      logic del;       // close the slot at the hit point and shift left
   } cell_ctl_type;

endpackage

/* design/sus_if.sv */
// Valid/ready channel interfaces for request and response transfers.
// Depends on sus_pkg for the payload types.
interface sus_req_if import sus_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   value_type           value;
   logic [POS_W-1:0]    position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

interface sus_rsp_if import sus_pkg::*; #(parameter int COUNT_W = 5) ();
   logic               valid;
   logic               ready;
   logic               found;
   value_type          element;
   logic [COUNT_W-1:0] count;
   logic [ERROR_W-1:0] error;

   modport source (output valid, found, element, count, error, input ready);
   modport sink   (input valid, found, element, count, error, output ready);
endinterface

/* design/sus_cell.sv */
// One slot of the sorted chain: holds an element, compares it against the
// request, and shifts to or from its neighbors. Depends on sus_pkg.
module sus_cell import sus_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             valid,        // slot lies below the fill count
   input  cell_ctl_type     ctl,
   input  value_type        cmp_value,    // value of the incoming request
   input  logic [POS_W-1:0] position,     // position of the incoming request
   input  value_type        ins_value,    // value being inserted
   input  value_type        left_entry,
   input  logic             left_lt,
   input  value_type        right_entry,
   output value_type        entry,
   output logic             lt,
   output logic             eq,
   output logic             sel
);

   value_type entry_ff, entry_in;
   logic      lt_ff, eq_ff, sel_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         lt_ff  <= valid && (entry_ff < cmp_value);
         eq_ff  <= valid && (entry_ff == cmp_value);
         sel_ff <= valid && (position == POS_W'(INDEX));
      end
      entry_ff <= entry_in;
   end

   // Cells below the insert or delete point keep their element.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && !lt_ff) begin
         entry_in = left_lt ? ins_value : left_entry;
      end else if (ctl.del && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign sel   = sel_ff;

endmodule

/* design/sorted_unique_set.sv */
// Top level of the sorted unique set: a chain of compare-and-shift cells
// plus the fill counter and the response register. Depends on sus_pkg,
// sus_if (channel interfaces) and sus_cell.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------
//   req_if   | in        | action, value, position
//   rsp_if   | out       | found, element, count, error
//
// Each request is handled in steps: the compare flags are first registered in
// every cell, then combined while the chain shifts and the response register
// is loaded. A new request is taken once that final step is done.
// Reset clears the fill count and the handshake state; the stored elements
// are not cleared. When the response register is still full the final
// step waits until that result leaves, and the input stays closed while a
// request is held, so at most one request and one result are in flight.
module sorted_unique_set import sus_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input logic       clock,
   input logic       reset,
   sus_req_if.sink   req_if,
   sus_rsp_if.source rsp_if
);

   // The rsp_if COUNT_W parameter must equal CNT_W.
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Control state.
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Request held until its response is formed.
   logic [ACTION_W-1:0] op_ff;
   value_type           value_ff;
   logic                range_ok_ff;

   // Response payload.
   logic             found_ff, found_in;
   value_type        element_ff, element_in;
   logic [CNT_W-1:0] count_ff;
   logic [ERROR_W-1:0] error_ff, error_in;

   logic [CAPACITY-1:0] valid_vec, lt_vec, eq_vec, sel_vec;
   value_type           entry_vec [CAPACITY];

   cell_ctl_type ctl;
   logic         req_fire, out_free, finish, hit, full;
   value_type    read_data;

   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = !busy_ff;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign finish       = busy_ff && out_free;
   assign hit          = |eq_vec;
   assign full         = (fill_ff == CNT_W'(CAPACITY));

   assign ctl = '{
      capture: req_fire,
      ins:     finish && (op_ff == ACT_INSERT) && !hit && !full,
      del:     finish && (op_ff == ACT_DELETE) && hit
   };

   // The chain. Cell 0 sees a "smaller" left neighbor so that it takes the
   // new value when the insert point is the head; the last cell reloads
   // itself on a delete, which leaves a slot beyond the fill count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid_vec[i] = (CNT_W'(i) < fill_ff);

      sus_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .valid       (valid_vec[i]),
         .ctl         (ctl),
         .cmp_value   (req_if.value),
         .position    (req_if.position),
         .ins_value   (value_ff),
         .left_entry  ((i == 0) ? value_ff : entry_vec[(i == 0) ? 0 : i - 1]),
         .left_lt     ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
         .right_entry (entry_vec[(i == CAPACITY - 1) ? i : i + 1]),
         .entry       (entry_vec[i]),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i]),
         .sel         (sel_vec[i])
      );
   end

   // At most one cell is selected by the position, so an OR picks it out.
   always_comb begin
      read_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_vec[i]) begin
            read_data = read_data | entry_vec[i];
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = 1'b0;
      element_in   = '0;
      error_in     = ERR_OK;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (finish) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         unique case (op_ff)
            ACT_INSERT: begin
               found_in = hit;
               if (!hit && full) begin
                  error_in = ERR_FULL;
               end else if (!hit) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            ACT_DELETE: begin
               found_in = hit;
               if (hit) begin
                  fill_in = fill_ff - CNT_W'(1);
               end
            end
            ACT_TEST: begin
               found_in = hit;
            end
            ACT_INDEX: begin
               if (range_ok_ff) begin
                  element_in = read_data;
               end else begin
                  error_in = ERR_RANGE;
               end
            end
            ACT_CLEAR: begin
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (req_fire) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_if.action;
         value_ff    <= req_if.value;
         range_ok_ff <= (req_if.position < POS_W'(fill_ff));
      end
      if (finish) begin
         found_ff   <= found_in;
         element_ff <= element_in;
         count_ff   <= fill_in;
         error_ff   <= error_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.found   = found_ff;
   assign rsp_if.element = element_ff;
   assign rsp_if.count   = count_ff;
   assign rsp_if.error   = error_ff;

   // The fill count never goes past the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count exceeds capacity");

   // Elements are unique, so at most one cell can match the value.
   a_one_match: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(eq_vec))
      else $error("more than one cell matches");

   // The chain is sorted: the smaller-than flags form a run from the head.
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((lt_vec & (lt_vec + CAPACITY'(1))) == '0))
      else $error("compare flags are not a run from the head");

   // A full-set error is only reported when the set is at capacity.
   a_full_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && error_ff == ERR_FULL) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("full error reported below capacity");

   // An accepted request always completes into the response register.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished request did not load a response");

endmodule
